### src/sha256bh_pkg.sv
// ----------------------------------------------------------------------------
// sha256bh_pkg
// Shared types, constants and functions of the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256bh_pkg;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam logic [5:0] LEN_FILL = 6'd56;
    localparam logic [5:0] LAST_FILL = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [1:0] LAST_INDEX = 2'd3;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    typedef struct packed {
        logic       load_byte;
        logic [7:0] byte_val;
        logic       load_len;
        logic       step;
    } sched_ctrl_t;

    typedef struct packed {
        logic       start;
        logic       step;
        logic       fold;
        logic       init;
        logic [5:0] round;
    } round_ctrl_t;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

    function automatic logic [31:0] h_init(input logic [2:0] idx);
        unique case (idx)
            3'd0: h_init = 32'h6a09e667;
            3'd1: h_init = 32'hbb67ae85;
            3'd2: h_init = 32'h3c6ef372;
            3'd3: h_init = 32'ha54ff53a;
            3'd4: h_init = 32'h510e527f;
            3'd5: h_init = 32'h9b05688c;
            3'd6: h_init = 32'h1f83d9ab;
            3'd7: h_init = 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [31:0] k_const(input logic [5:0] idx);
        unique case (idx)
            6'd0:  k_const = 32'h428a2f98;
            6'd1:  k_const = 32'h71374491;
            6'd2:  k_const = 32'hb5c0fbcf;
            6'd3:  k_const = 32'he9b5dba5;
            6'd4:  k_const = 32'h3956c25b;
            6'd5:  k_const = 32'h59f111f1;
            6'd6:  k_const = 32'h923f82a4;
            6'd7:  k_const = 32'hab1c5ed5;
            6'd8:  k_const = 32'hd807aa98;
            6'd9:  k_const = 32'h12835b01;
            6'd10: k_const = 32'h243185be;
            6'd11: k_const = 32'h550c7dc3;
            6'd12: k_const = 32'h72be5d74;
            6'd13: k_const = 32'h80deb1fe;
            6'd14: k_const = 32'h9bdc06a7;
            6'd15: k_const = 32'hc19bf174;
            6'd16: k_const = 32'he49b69c1;
            6'd17: k_const = 32'hefbe4786;
            6'd18: k_const = 32'h0fc19dc6;
            6'd19: k_const = 32'h240ca1cc;
            6'd20: k_const = 32'h2de92c6f;
            6'd21: k_const = 32'h4a7484aa;
            6'd22: k_const = 32'h5cb0a9dc;
            6'd23: k_const = 32'h76f988da;
            6'd24: k_const = 32'h983e5152;
            6'd25: k_const = 32'ha831c66d;
            6'd26: k_const = 32'hb00327c8;
            6'd27: k_const = 32'hbf597fc7;
            6'd28: k_const = 32'hc6e00bf3;
            6'd29: k_const = 32'hd5a79147;
            6'd30: k_const = 32'h06ca6351;
            6'd31: k_const = 32'h14292967;
            6'd32: k_const = 32'h27b70a85;
            6'd33: k_const = 32'h2e1b2138;
            6'd34: k_const = 32'h4d2c6dfc;
            6'd35: k_const = 32'h53380d13;
            6'd36: k_const = 32'h650a7354;
            6'd37: k_const = 32'h766a0abb;
            6'd38: k_const = 32'h81c2c92e;
            6'd39: k_const = 32'h92722c85;
            6'd40: k_const = 32'ha2bfe8a1;
            6'd41: k_const = 32'ha81a664b;
            6'd42: k_const = 32'hc24b8b70;
            6'd43: k_const = 32'hc76c51a3;
            6'd44: k_const = 32'hd192e819;
            6'd45: k_const = 32'hd6990624;
            6'd46: k_const = 32'hf40e3585;
            6'd47: k_const = 32'h106aa070;
            6'd48: k_const = 32'h19a4c116;
            6'd49: k_const = 32'h1e376c08;
            6'd50: k_const = 32'h2748774c;
            6'd51: k_const = 32'h34b0bcb5;
            6'd52: k_const = 32'h391c0cb3;
            6'd53: k_const = 32'h4ed8aa4a;
            6'd54: k_const = 32'h5b9cca4f;
            6'd55: k_const = 32'h682e6ff3;
            6'd56: k_const = 32'h748f82ee;
            6'd57: k_const = 32'h78a5636f;
            6'd58: k_const = 32'h84c87814;
            6'd59: k_const = 32'h8cc70208;
            6'd60: k_const = 32'h90befffa;
            6'd61: k_const = 32'ha4506ceb;
            6'd62: k_const = 32'hbef9a3f7;
            6'd63: k_const = 32'hc67178f2;
        endcase
    endfunction

endpackage

`default_nettype wire

### src/sha256bh_sched.sv
// ----------------------------------------------------------------------------
// sha256bh_sched
// Block buffer and message schedule: bytes shift in, then a sixteen-word
// window slides one word per round.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256bh_sched (
    input  wire logic                      clk,
    input  wire sha256bh_pkg::sched_ctrl_t ctrl,
    input  wire logic [63:0]               msg_len,
    output logic [31:0]                    w_cur
);
    import sha256bh_pkg::*;

    logic [511:0] blk_reg;
    logic [511:0] blk_next;
    logic [31:0]  w_new;

    assign w_cur = blk_reg[511:480];
    assign w_new = small_sigma1(blk_reg[63:32]) + blk_reg[223:192]
                 + small_sigma0(blk_reg[479:448]) + blk_reg[511:480];

    always_comb
    begin
        priority if (ctrl.load_byte)
        begin
            blk_next = {blk_reg[503:0], ctrl.byte_val};
        end
        else if (ctrl.load_len)
        begin
            blk_next = {blk_reg[447:0], msg_len};
        end
        else if (ctrl.step)
        begin
            blk_next = {blk_reg[479:0], w_new};
        end
        else
        begin
            blk_next = blk_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

endmodule

`default_nettype wire

### src/sha256bh_round.sv
// ----------------------------------------------------------------------------
// sha256bh_round
// Shared compression round and the eight chaining words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256bh_round (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire sha256bh_pkg::round_ctrl_t ctrl,
    input  wire logic [31:0]               w_cur,
    output logic [7:0][31:0]               chain
);
    import sha256bh_pkg::*;

    logic [7:0][31:0] chain_reg;
    logic [7:0][31:0] chain_next;
    logic [7:0][31:0] chain_init;
    logic [7:0][31:0] v_reg;
    logic [7:0][31:0] v_next;
    logic [31:0]      t1;
    logic [31:0]      t2;
    logic [31:0]      ch;
    logic [31:0]      maj;

    assign chain = chain_reg;

    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + big_sigma1(v_reg[4]) + ch + k_const(ctrl.round) + w_cur;
    assign t2  = big_sigma0(v_reg[0]) + maj;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            chain_init[i] = h_init(3'(i));
        end
    end

    always_comb
    begin
        priority if (ctrl.start)
        begin
            v_next = chain_reg;
        end
        else if (ctrl.step)
        begin
            v_next = {v_reg[6], v_reg[5], v_reg[4], v_reg[3] + t1,
                      v_reg[2], v_reg[1], v_reg[0], t1 + t2};
        end
        else
        begin
            v_next = v_reg;
        end
    end

    always_comb
    begin
        priority if (ctrl.init)
        begin
            chain_next = chain_init;
        end
        else if (ctrl.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_next[i] = chain_reg[i] + v_reg[i];
            end
        end
        else
        begin
            chain_next = chain_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= chain_init;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

endmodule

`default_nettype wire

### src/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, digest out as four 64-bit big-endian words.
// ----------------------------------------------------------------------------
// An absorb word is accepted whenever the block is idle. Every 64th byte then
// holds the input while the block runs 64 rounds through the one shared round
// unit and then folds the result into the chaining words. A finish word appends
// 0x80, then zero bytes one per cycle up to byte 56, loads the bit length and
// compresses; with more than 55 bytes buffered a second block, with its zero
// fill, comes first. The four digest words follow, one per accepted output
// cycle, and the block returns to its initial state.
`default_nettype none

module sha256_byte_stream_hasher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  wire logic [0:0]  s_axis_tuser,   // operation[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // digest_word[63:0]
    output logic [1:0]       m_axis_tuser,   // word_index[1:0]
    output logic             m_axis_tlast
);
    import sha256bh_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUNDS,
        ST_FOLD,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [5:0]       fill_reg;
    logic [5:0]       fill_next;
    logic [63:0]      bits_reg;
    logic [63:0]      bits_next;
    logic [5:0]       rnd_reg;
    logic [5:0]       rnd_next;
    logic [1:0]       idx_reg;
    logic [1:0]       idx_next;
    logic             final_reg;
    logic             final_next;
    logic             padding_reg;
    logic             padding_next;
    logic             in_acc;
    sched_ctrl_t      sc;
    round_ctrl_t      rc;
    logic [31:0]      w_cur;
    logic [7:0][31:0] chain;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tdata  = {chain[{idx_reg, 1'b0}], chain[{idx_reg, 1'b1}]};
    assign m_axis_tuser  = idx_reg;
    assign m_axis_tlast  = (idx_reg == LAST_INDEX);

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        bits_next    = bits_reg;
        rnd_next     = rnd_reg;
        idx_next     = idx_reg;
        final_next   = final_reg;
        padding_next = padding_reg;
        sc           = '0;
        rc           = '0;
        rc.round     = rnd_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    sc.load_byte = 1'b1;
                    fill_next    = fill_reg + 6'd1;
                    if (s_axis_tuser[0] == OP_ABSORB)
                    begin
                        sc.byte_val = s_axis_tdata;
                        bits_next   = bits_reg + BITS_PER_BYTE;
                    end
                    else
                    begin
                        sc.byte_val  = PAD_BYTE;
                        padding_next = 1'b1;
                    end
                    priority if (fill_reg == LAST_FILL)
                    begin
                        state_next = ST_ROUNDS;
                        rc.start   = 1'b1;
                        rnd_next   = '0;
                    end
                    else if (s_axis_tuser[0] == OP_FINISH)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PAD:
            begin
                if (fill_reg == LEN_FILL)
                begin
                    sc.load_len = 1'b1;
                    final_next  = 1'b1;
                    fill_next   = '0;
                    state_next  = ST_ROUNDS;
                    rc.start    = 1'b1;
                    rnd_next    = '0;
                end
                else
                begin
                    sc.load_byte = 1'b1;
                    sc.byte_val  = ZERO_BYTE;
                    fill_next    = fill_reg + 6'd1;
                    if (fill_reg == LAST_FILL)
                    begin
                        state_next = ST_ROUNDS;
                        rc.start   = 1'b1;
                        rnd_next   = '0;
                    end
                end
            end
            ST_ROUNDS:
            begin
                sc.step  = 1'b1;
                rc.step  = 1'b1;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                rc.fold = 1'b1;
                priority if (final_reg)
                begin
                    state_next = ST_EMIT;
                    idx_next   = '0;
                end
                else if (padding_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (m_axis_tready)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == LAST_INDEX)
                    begin
                        rc.init      = 1'b1;
                        bits_next    = '0;
                        fill_next    = '0;
                        final_next   = 1'b0;
                        padding_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            bits_reg    <= '0;
            rnd_reg     <= '0;
            idx_reg     <= '0;
            final_reg   <= 1'b0;
            padding_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            bits_reg    <= bits_next;
            rnd_reg     <= rnd_next;
            idx_reg     <= idx_next;
            final_reg   <= final_next;
            padding_reg <= padding_next;
        end
    end

    sha256bh_sched u_sched (
        .clk     (clk),
        .ctrl    (sc),
        .msg_len (bits_reg),
        .w_cur   (w_cur)
    );

    sha256bh_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rc),
        .w_cur (w_cur),
        .chain (chain)
    );

`ifndef SYNTHESIS
    a_ready_excludes_valid: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while digest word pending");

    a_last_word_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && fill_reg == '0)
        else $error("block not cleared after final digest word");

    a_round_count_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUNDS && rnd_reg == LAST_ROUND |=> state_reg == ST_FOLD)
        else $error("compression did not fold after last round");

    a_sched_single_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({sc.load_byte, sc.load_len, sc.step}))
        else $error("conflicting block buffer operations");

    a_start_only_on_entry: assert property (@(posedge clk) disable iff (!rst_n)
        rc.start |=> state_reg == ST_ROUNDS && rnd_reg == '0)
        else $error("round start without round sequence");
`endif

endmodule

`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams byte messages into the SHA-256 hasher and checks every digest word
// against a SHA-256 computed alongside in the bench. Directed short messages
// come first, then random messages, many with lengths around the padding and
// block boundaries, under three source/sink throttling profiles.
// ----------------------------------------------------------------------------

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import sha256bh_pkg::*;

    typedef struct {
        logic [63:0] digest;
        logic [1:0]  index;
        logic        last;
    } digest_word_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] CHAIN_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic [0:0]  s_axis_tuser = OP_ABSORB;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    logic [31:0]  hash_words [8];
    logic [7:0]   block_bytes [64];
    int unsigned  block_fill;
    logic [63:0]  message_bit_count;
    digest_word_t pending_words [$];

    int src_idle_pct;
    int snk_idle_pct;
    int mismatches;

    sha256_byte_stream_hasher i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        logic [63:0] twice;
        twice = {x, x} >> n;
        return twice[31:0];
    endfunction

    function automatic void hash_restart();
        for (int i = 0; i < 8; i++)
            hash_words[i] = CHAIN_IV[i];
        block_fill = 0;
        message_bit_count = '0;
    endfunction

    function automatic void hash_fold_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
        e = hash_words[4]; f = hash_words[5]; g = hash_words[6]; h = hash_words[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_K[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
        hash_words[4] += e; hash_words[5] += f; hash_words[6] += g; hash_words[7] += h;
    endfunction

    function automatic void hash_absorb(input logic [7:0] data);
        block_bytes[block_fill] = data;
        block_fill++;
        message_bit_count += 64'd8;
        if (block_fill == 64)
        begin
            hash_fold_block();
            block_fill = 0;
        end
    endfunction

    function automatic void hash_finish();
        digest_word_t dw;
        block_bytes[block_fill] = 8'h80;
        block_fill++;
        if (block_fill > 56)
        begin
            while (block_fill < 64)
            begin
                block_bytes[block_fill] = 8'h00;
                block_fill++;
            end
            hash_fold_block();
            block_fill = 0;
        end
        while (block_fill < 56)
        begin
            block_bytes[block_fill] = 8'h00;
            block_fill++;
        end
        for (int k = 0; k < 8; k++)
            block_bytes[56+k] = message_bit_count[8*(7-k) +: 8];
        hash_fold_block();
        for (int k = 0; k < 4; k++)
        begin
            dw.digest = {hash_words[2*k], hash_words[2*k+1]};
            dw.index = 2'(k);
            dw.last = (k == 3);
            pending_words = {pending_words, dw};
        end
        hash_restart();
    endfunction

    task automatic send_word(input logic op, input logic [7:0] data);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= data;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (op == OP_FINISH)
            hash_finish();
        else
            hash_absorb(data);
    endtask

    task automatic send_message(input int len, input logic [7:0] bytes [$]);
        for (int i = 0; i < len; i++)
            send_word(OP_ABSORB, bytes[i]);
        send_word(OP_FINISH, 8'($urandom_range(255)));
    endtask

    task automatic check_digest_word();
        digest_word_t want;
        if (pending_words.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%t: unexpected digest word %h index %0d last %b", $realtime,
                         m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
        else
        begin
            want = pending_words.pop_front();
            if (m_axis_tdata !== want.digest || m_axis_tuser !== want.index
                || m_axis_tlast !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: expected %h index %0d last %b, got %h index %0d last %b",
                             $realtime, want.digest, want.index, want.last,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                check_digest_word();
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic test_empty_message();
        logic [7:0] none [$];
        send_message(0, none);
        send_message(0, none);
    endtask

    task automatic test_single_bytes();
        logic [7:0] msg [$];
        msg = '{8'h00};
        send_message(1, msg);
        msg = '{8'hff};
        send_message(1, msg);
        msg = '{8'h61, 8'h62, 8'h63};
        send_message(3, msg);
    endtask

    // Hold a throttling profile; lengths cluster around the padding and
    // block edges, the rest short or mid-sized.
    task automatic test_random_messages(input int src_pct, input int snk_pct, input int n_items);
        int sent;
        int len;
        int pick;
        logic [7:0] msg [$];
        int boundary_lens [11] = '{55, 56, 57, 62, 63, 64, 65, 119, 120, 127, 128};
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                len = $urandom_range(15);
            else if (pick < 80)
                len = boundary_lens[$urandom_range(10)];
            else
                len = $urandom_range(130, 16);
            if (len > n_items - sent - 1)
                len = n_items - sent - 1;
            msg.delete();
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(9) == 0)
                    msg = {msg, ($urandom_range(1) ? 8'hff : 8'h00)};
                else
                    msg = {msg, 8'($urandom_range(255))};
            end
            send_message(len, msg);
            sent += len + 1;
        end
    endtask

    initial
    begin
        mismatches = 0;
        src_idle_pct = 28;
        snk_idle_pct = 71;
        hash_restart();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_message();
        test_single_bytes();
        test_random_messages(28, 71, 120);
        test_random_messages(71, 28, 120);
        test_random_messages(0, 0, 120);

        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
